FILE: rtl/jss_pkg.sv
`timescale 1ns / 1ps
// Package for the JPEG start-of-frame size scanner.
// Holds marker codes, phase enum, multiplier handshake structs and marker classifiers.
package jss_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned DimW  = 16;
  localparam int unsigned OpAW  = 24;
  localparam int unsigned ProdW = 40;
  localparam int unsigned MulStepW = 4;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] SofFirst     = 8'hC0;
  localparam logic [7:0] SofLast      = 8'hCF;
  localparam logic [7:0] CodeDht      = 8'hC4;
  localparam logic [7:0] CodeJpg      = 8'hC8;
  localparam logic [7:0] CodeDac      = 8'hCC;
  localparam logic [7:0] CodeSoi      = 8'hD8;
  localparam logic [7:0] CodeTem      = 8'h01;
  localparam logic [7:0] RstFirst     = 8'hD0;
  localparam logic [7:0] RstLast      = 8'hD7;

  localparam logic [2:0] SofOffHiH   = 3'd3;
  localparam logic [2:0] SofOffLoH   = 3'd4;
  localparam logic [2:0] SofOffHiW   = 3'd5;
  localparam logic [2:0] SofOffLoW   = 3'd6;
  localparam logic [2:0] SofOffComps = 3'd7;

  typedef enum logic [3:0] {
    PH_SKIP0,
    PH_SKIP1,
    PH_HUNT,
    PH_CODE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIPPING,
    PH_SOF,
    PH_MUL1,
    PH_MUL2,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic            start;
    logic [OpAW-1:0] a;
    logic [DimW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] product;
  } mul_rsp_t;

  function automatic logic is_sof(input logic [7:0] c);
    return (c inside {[SofFirst:SofLast]}) && !(c inside {CodeDht, CodeJpg, CodeDac});
  endfunction

  function automatic logic is_standalone(input logic [7:0] c);
    return c inside {CodeSoi, CodeTem, [RstFirst:RstLast]};
  endfunction

endpackage

FILE: rtl/jss_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle across the 16-bit multiplier.
// Depends on jss_pkg for widths and the request/response structs.
module jss_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jss_pkg::mul_req_t req_i,
  output jss_pkg::mul_rsp_t rsp_o
);
  import jss_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [MulStepW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0]    acc_q, acc_d;
  logic [ProdW-1:0]    mcand_q, mcand_d;
  logic [DimW-1:0]     mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = '0;
      mcand_d  = {{(ProdW-OpAW){1'b0}}, req_i.a};
      mplier_d = req_i.b;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[ProdW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[DimW-1:1]};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == {MulStepW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

FILE: rtl/jpeg_sof_size_scanner.sv
`timescale 1ns / 1ps
// Top level of the JPEG start-of-frame size scanner.
// Depends on jss_pkg and jss_mul.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one file byte per item with
//   last_i marking the final byte. Output channel (out_valid_o / out_ready_i)
//   carries image_bytes_o and found_o, at most one result per file.
//   The first two bytes are dropped; markers are then parsed. The first SOF
//   header yields width * height * components with found_o set; a file that
//   ends first yields zero with found_o clear on its last byte.
// Timing:
//   Ordinary bytes are taken one per cycle. A result for a last byte is
//   registered and appears in the cycle after it is taken. The component-count
//   byte of a SOF starts two passes through the shared 16-step shift-add
//   multiplier (height times components, then times width); no byte is taken
//   until the product is registered as the result.
//   A byte that can produce a result is held off while a result waits on the
//   output; other bytes keep flowing while the receiver stalls.
// Reset:
//   Asynchronous active-low reset returns the parser to the start of a file
//   and empties the output register.
module jpeg_sof_size_scanner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jss_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [jss_pkg::ProdW-1:0] image_bytes_o,
  output logic                      found_o
);
  import jss_pkg::*;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_hi_q, len_hi_d;
  logic [DimW-1:0]   skip_q, skip_d;
  logic [2:0]        sof_off_q, sof_off_d;
  logic [DimW-1:0]   height_q, height_d;
  logic [DimW-1:0]   width_q, width_d;
  logic              last_pend_q, last_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [ProdW-1:0]  image_bytes_q, image_bytes_d;
  logic              found_q, found_d;

  logic              accept;
  logic              sof_final;
  logic              produces;
  logic [DimW-1:0]   seg_len;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  assign sof_final = (phase_q == PH_SOF) && (sof_off_q == SofOffComps);
  assign produces  = last_i || sof_final;
  assign accept    = in_valid_i && in_ready_o;
  assign seg_len   = {len_hi_q, data_byte_i};

  jss_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // next state
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        PH_SKIP0:    phase_d = PH_SKIP1;
        PH_SKIP1:    phase_d = PH_HUNT;
        PH_CODE: begin
          if (is_sof(data_byte_i)) begin
            phase_d = PH_SOF;
          end else if (is_standalone(data_byte_i)) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI:   phase_d = PH_LEN_LO;
        PH_LEN_LO:   phase_d = (seg_len <= DimW'(2)) ? PH_HUNT : PH_SKIPPING;
        PH_SKIPPING: phase_d = (skip_q == DimW'(1)) ? PH_HUNT : PH_SKIPPING;
        PH_SOF:      phase_d = sof_final ? PH_MUL1 : PH_SOF;
        PH_DONE:     phase_d = PH_DONE;
        default:     phase_d = (data_byte_i == MarkerPrefix) ? PH_CODE : PH_HUNT;
      endcase
      if (last_i && !sof_final) begin
        phase_d = PH_SKIP0;
      end
    end else if (mul_rsp.done) begin
      case (phase_q)
        PH_MUL1: phase_d = PH_MUL2;
        PH_MUL2: phase_d = last_pend_q ? PH_SKIP0 : PH_DONE;
        default: phase_d = phase_q;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    in_ready_o    = 1'b0;
    mul_req       = '0;
    len_hi_d      = len_hi_q;
    skip_d        = skip_q;
    sof_off_d     = sof_off_q;
    height_d      = height_q;
    width_d       = width_q;
    last_pend_d   = last_pend_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    image_bytes_d = image_bytes_q;
    found_d       = found_q;

    case (phase_q)
      PH_MUL1, PH_MUL2: in_ready_o = 1'b0;
      default:          in_ready_o = !out_valid_q || !produces;
    endcase

    if (accept) begin
      case (phase_q)
        PH_CODE:     sof_off_d = '0;
        PH_LEN_HI:   len_hi_d = data_byte_i;
        PH_LEN_LO:   skip_d = seg_len - DimW'(2);
        PH_SKIPPING: skip_d = skip_q - DimW'(1);
        PH_SOF: begin
          case (sof_off_q)
            SofOffHiH: height_d = {data_byte_i, height_q[ByteW-1:0]};
            SofOffLoH: height_d = {height_q[DimW-1:ByteW], data_byte_i};
            SofOffHiW: width_d  = {data_byte_i, width_q[ByteW-1:0]};
            SofOffLoW: width_d  = {width_q[DimW-1:ByteW], data_byte_i};
            default:   ;
          endcase
          if (sof_final) begin
            last_pend_d   = last_i;
            mul_req.start = 1'b1;
            mul_req.a     = {{(OpAW-DimW){1'b0}}, height_q};
            mul_req.b     = {{(DimW-ByteW){1'b0}}, data_byte_i};
          end else begin
            sof_off_d = sof_off_q + 3'd1;
          end
        end
        default: ;
      endcase
      if (last_i && !sof_final && phase_q != PH_DONE) begin
        out_valid_d   = 1'b1;
        image_bytes_d = '0;
        found_d       = 1'b0;
      end
    end else if (mul_rsp.done) begin
      case (phase_q)
        PH_MUL1: begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product[OpAW-1:0];
          mul_req.b     = width_q;
        end
        PH_MUL2: begin
          out_valid_d   = 1'b1;
          image_bytes_d = mul_rsp.product;
          found_d       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP0;
      out_valid_q <= 1'b0;
      last_pend_q <= 1'b0;
      skip_q      <= '0;
      sof_off_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      last_pend_q <= last_pend_d;
      skip_q      <= skip_d;
      sof_off_q   <= sof_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_hi_q      <= len_hi_d;
    height_q      <= height_d;
    width_q       <= width_d;
    image_bytes_q <= image_bytes_d;
    found_q       <= found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign image_bytes_o = image_bytes_q;
  assign found_o       = found_q;

  a_no_intake_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(phase_q == PH_MUL1 || phase_q == PH_MUL2))
    else $error("byte taken during multiply");

  a_mul_done_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (phase_q == PH_MUL1 || phase_q == PH_MUL2))
    else $error("multiplier finished outside a multiply phase");

  a_result_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_rsp.done && phase_q == PH_MUL2) |-> !out_valid_q)
    else $error("product would overwrite a waiting result");

  a_not_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (image_bytes_o == '0))
    else $error("nonzero size without a frame header");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_sof_size_scanner: streams JPEG-like files byte by byte
// and checks every size result against a built-in frame-size predictor.
// Depends on jss_pkg and the scanner RTL only.
module testbench;
  import jss_pkg::*;

  typedef enum logic [3:0] {
    SCAN_SKIP0,
    SCAN_SKIP1,
    SCAN_HUNT,
    SCAN_CODE,
    SCAN_LEN_HI,
    SCAN_LEN_LO,
    SCAN_SKIPPING,
    SCAN_SOF,
    SCAN_DONE
  } scan_e;

  typedef struct packed {
    logic [ProdW-1:0] image_bytes;
    logic             found;
  } size_res_t;

  localparam logic [7:0] CodeDqt = 8'hDB;
  localparam logic [7:0] CodeApp0 = 8'hE0;
  localparam logic [7:0] CodeEoi = 8'hD9;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i;
  logic             last_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ProdW-1:0] image_bytes_o;
  logic             found_o;

  scan_e       scan_ph;
  logic [16:0] seg_left;
  logic [7:0]  len_hi_q;
  logic [3:0]  hdr_idx;
  logic [15:0] height_q;
  logic [15:0] width_q;

  size_res_t  size_q[$];
  logic [7:0] file_q[$];

  int idle_pct;
  int stall_pct;
  int n_err;
  int n_bytes;
  int n_files;
  int n_results;
  int n_found;

  jpeg_sof_size_scanner i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .image_bytes_o(image_bytes_o),
    .found_o      (found_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d size results outstanding", size_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic sof_code(input logic [7:0] c);
    return c >= SofFirst && c <= SofLast && c != CodeDht && c != CodeJpg && c != CodeDac;
  endfunction

  function automatic logic standalone_code(input logic [7:0] c);
    return c == CodeSoi || c == CodeTem || (c >= RstFirst && c <= RstLast);
  endfunction

  function automatic void clear_scan();
    scan_ph  = SCAN_SKIP0;
    seg_left = '0;
    len_hi_q = '0;
    hdr_idx  = '0;
    height_q = '0;
    width_q  = '0;
  endfunction

  function automatic void frame_size_step(input logic [7:0] b, input logic lst);
    logic        was_done;
    logic        emitted;
    logic [16:0] seg_len;
    logic [39:0] h40;
    logic [39:0] w40;
    logic [39:0] c40;
    size_res_t   r;
    was_done = (scan_ph == SCAN_DONE);
    emitted  = 1'b0;
    case (scan_ph)
      SCAN_SKIP0: scan_ph = SCAN_SKIP1;
      SCAN_SKIP1: scan_ph = SCAN_HUNT;
      SCAN_CODE: begin
        if (sof_code(b)) begin
          hdr_idx = '0;
          scan_ph = SCAN_SOF;
        end else if (standalone_code(b)) begin
          scan_ph = SCAN_HUNT;
        end else begin
          scan_ph = SCAN_LEN_HI;
        end
      end
      SCAN_LEN_HI: begin
        len_hi_q = b;
        scan_ph  = SCAN_LEN_LO;
      end
      SCAN_LEN_LO: begin
        seg_len = {1'b0, len_hi_q, b};
        if (seg_len <= 17'd2) begin
          scan_ph = SCAN_HUNT;
        end else begin
          seg_left = seg_len - 17'd2;
          scan_ph  = SCAN_SKIPPING;
        end
      end
      SCAN_SKIPPING: begin
        if (seg_left != 0) seg_left = seg_left - 17'd1;
        if (seg_left == 0) scan_ph = SCAN_HUNT;
      end
      SCAN_SOF: begin
        case (hdr_idx)
          4'd3: height_q = {b, 8'h00};
          4'd4: height_q[7:0] = b;
          4'd5: width_q = {b, 8'h00};
          4'd6: width_q[7:0] = b;
          default: ;
        endcase
        if (hdr_idx >= 4'd7) begin
          h40 = {24'b0, height_q};
          w40 = {24'b0, width_q};
          c40 = {32'b0, b};
          r.image_bytes = w40 * h40 * c40;
          r.found = 1'b1;
          size_q.push_back(r);
          emitted = 1'b1;
          scan_ph = SCAN_DONE;
        end else begin
          hdr_idx = hdr_idx + 4'd1;
        end
      end
      SCAN_DONE: ;
      default: scan_ph = (b == MarkerPrefix) ? SCAN_CODE : SCAN_HUNT;
    endcase
    if (lst) begin
      if (!emitted && !was_done) begin
        r.image_bytes = '0;
        r.found = 1'b0;
        size_q.push_back(r);
      end
      clear_scan();
    end
  endfunction

  always @(posedge clk_i) begin
    size_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (size_q.size() == 0) begin
          if (n_err < 10)
            $display("Unexpected size result image_bytes=%0d found=%0b", image_bytes_o, found_o);
          n_err++;
        end else begin
          want = size_q.pop_front();
          if (want.found) n_found++;
          if (image_bytes_o !== want.image_bytes || found_o !== want.found) begin
            if (n_err < 10)
              $display("Size mismatch: image_bytes exp %0d got %0d, found exp %0b got %0b",
                       want.image_bytes, image_bytes_o, want.found, found_o);
            n_err++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frame_size_step(b, lst);
    n_bytes++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    n_files++;
  endtask

  task automatic open_file();
    file_q.delete();
    file_q.push_back(MarkerPrefix);
    file_q.push_back(CodeSoi);
  endtask

  task automatic add_sof(input logic [7:0] code, input logic [15:0] h, input logic [15:0] w,
                         input logic [7:0] comps);
    file_q.push_back(MarkerPrefix);
    file_q.push_back(code);
    file_q.push_back(8'h00);
    file_q.push_back(8'h11);
    file_q.push_back(8'h08);
    file_q.push_back(h[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(w[7:0]);
    file_q.push_back(comps);
  endtask

  task automatic add_segment(input logic [7:0] code, input logic [15:0] len);
    file_q.push_back(MarkerPrefix);
    file_q.push_back(code);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    for (int i = 2; i < len; i++) file_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_standalone(input logic [7:0] code);
    file_q.push_back(MarkerPrefix);
    file_q.push_back(code);
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(16'hFFFF));
      default: return 16'($urandom_range(2000, 1));
    endcase
  endfunction

  task automatic build_random_file();
    logic [7:0]  code;
    logic [15:0] len;
    int          cut;
    file_q.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(40, 1))
        file_q.push_back(($urandom_range(3) == 0) ? MarkerPrefix : 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(9) == 0) begin
        file_q.push_back(8'($urandom_range(255)));
        file_q.push_back(8'($urandom_range(255)));
      end else begin
        open_file();
      end
      repeat ($urandom_range(3)) begin
        case ($urandom_range(3))
          0: begin
            case ($urandom_range(2))
              0: add_standalone(CodeTem);
              1: add_standalone(CodeSoi);
              default: add_standalone(RstFirst + 8'($urandom_range(7)));
            endcase
          end
          1: file_q.push_back(8'($urandom_range(254)));
          default: begin
            do code = 8'($urandom_range(255)); while (sof_code(code) || standalone_code(code));
            if ($urandom_range(39) == 0) len = {8'($urandom_range(2, 1)), 8'($urandom_range(255))};
            else len = 16'($urandom_range(12));
            add_segment(code, len);
          end
        endcase
      end
      if ($urandom_range(9) < 8) begin
        do code = SofFirst + 8'($urandom_range(15)); while (!sof_code(code));
        case ($urandom_range(3))
          0: add_sof(code, pick_dim(), pick_dim(), 8'h00);
          1: add_sof(code, pick_dim(), pick_dim(), 8'hFF);
          default: add_sof(code, pick_dim(), pick_dim(), 8'($urandom_range(4, 1)));
        endcase
        file_q[file_q.size() - 8] = 8'($urandom_range(255));
        file_q[file_q.size() - 7] = 8'($urandom_range(255));
        file_q[file_q.size() - 6] = 8'($urandom_range(255));
      end
      repeat ($urandom_range(6)) file_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(file_q.size(), 1);
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
    end
  endtask

  task automatic test_sof_extremes();
    open_file();
    add_sof(SofFirst, 16'hFFFF, 16'hFFFF, 8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(MarkerPrefix);
    send_file();
    open_file();
    add_sof(SofLast, 16'h0001, 16'h0000, 8'h03);
    send_file();
    open_file();
    add_sof(8'hC3, 16'h0000, 16'h0000, 8'h00);
    file_q.push_back(8'h7F);
    send_file();
  endtask

  task automatic test_marker_kinds();
    open_file();
    add_standalone(CodeTem);
    add_standalone(RstFirst);
    add_standalone(RstLast);
    add_standalone(CodeSoi);
    file_q.push_back(8'h00);
    add_segment(CodeDht, 16'd4);
    add_segment(CodeJpg, 16'd3);
    add_segment(CodeDac, 16'd5);
    add_segment(MarkerPrefix, 16'd3);
    add_segment(CodeEoi, 16'd2);
    file_q.push_back(8'h7F);
    add_sof(8'hC1, 16'h0010, 16'h0020, 8'h03);
    send_file();
  endtask

  task automatic test_short_lengths();
    open_file();
    add_segment(CodeDqt, 16'd0);
    add_segment(CodeDqt, 16'd1);
    add_segment(CodeDqt, 16'd2);
    add_segment(CodeApp0, 16'h0103);
    add_sof(8'hC2, 16'h0100, 16'h0080, 8'h01);
    send_file();
  endtask

  task automatic test_truncated();
    file_q.delete();
    file_q.push_back(8'hAA);
    send_file();
    open_file();
    send_file();
    for (int n = 3; n <= 7; n++) begin
      open_file();
      add_segment(CodeApp0, 16'd16);
      while (file_q.size() > n) void'(file_q.pop_back());
      send_file();
    end
    open_file();
    add_sof(SofFirst, 16'h1234, 16'h5678, 8'h03);
    void'(file_q.pop_back());
    send_file();
  endtask

  task automatic test_random_files(input int sender_idle, input int recv_stall, input int quota);
    int first;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    first     = n_bytes;
    while (n_bytes - first < quota) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    last_i      <= 1'b0;
    out_ready_i <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    n_err     = 0;
    n_bytes   = 0;
    n_files   = 0;
    n_results = 0;
    n_found   = 0;
    clear_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sof_extremes();
    test_marker_kinds();
    test_short_lengths();
    test_truncated();
    test_random_files(0, 0, 335);
    test_random_files(47, 0, 335);
    test_random_files(0, 47, 335);
    test_random_files(31, 31, 335);

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (size_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Streamed %0d bytes in %0d files; checked %0d size results, %0d with a frame header.",
             n_bytes, n_files, n_results, n_found);
    $display("Mismatches: %0d", n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
